@@ rtl/sia_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_pkg
// types and operation codes shared by the integer alu pipeline
// ----------------------------------------------------------------------------
package sia_pkg;

  localparam int unsigned OP_WIDTH = 5;
  localparam int unsigned VALUE_WIDTH = 32;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3, OP_MOD = 5'd4,
    OP_AND = 5'd5, OP_OR = 5'd6, OP_XOR = 5'd7, OP_SRA = 5'd8, OP_SLL = 5'd9,
    OP_SRL = 5'd10, OP_EQ = 5'd11, OP_NE = 5'd12, OP_LE = 5'd13, OP_GE = 5'd14,
    OP_LT = 5'd15, OP_GT = 5'd16, OP_LAND = 5'd17, OP_LOR = 5'd18,
    OP_POS = 5'd19, OP_NEG = 5'd20, OP_NOT = 5'd21
  } op_t;

  typedef struct packed {
    logic [OP_WIDTH-1:0]           operation;
    logic signed [VALUE_WIDTH-1:0] left_operand;
    logic signed [VALUE_WIDTH-1:0] right_operand;
  } in_beat_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] result_value;
    logic                          result_valid;
  } out_beat_t;

endpackage

@@ rtl/sia_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_divider
// pipelined unsigned restoring divider, BITS_PER_STAGE quotient bits a stage,
// with side data carried alongside; advances when en is high
// ----------------------------------------------------------------------------
module sia_divider #(
  parameter int unsigned WIDTH          = 32,
  parameter int unsigned BITS_PER_STAGE = 4,
  parameter int unsigned SIDE_WIDTH     = 8
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [WIDTH-1:0]      dividend,
  input  logic [WIDTH-1:0]      divisor,
  input  logic [SIDE_WIDTH-1:0] side_in,
  output logic [WIDTH-1:0]      quotient,
  output logic [WIDTH-1:0]      remainder,
  output logic [SIDE_WIDTH-1:0] side_out
);

  localparam int unsigned STAGES = (WIDTH + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

  logic [WIDTH-1:0]      num   [STAGES+1];
  logic [WIDTH-1:0]      rem   [STAGES+1];
  logic [WIDTH-1:0]      den   [STAGES+1];
  logic [SIDE_WIDTH-1:0] side  [STAGES+1];

  assign num[0]  = dividend;
  assign rem[0]  = '0;
  assign den[0]  = divisor;
  assign side[0] = side_in;

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic [WIDTH-1:0] num_next;
    logic [WIDTH-1:0] rem_next;

    always_comb begin
      logic [WIDTH:0] trial;
      trial = '0;
      num_next = num[g];
      rem_next = rem[g];
      for (int k = 0; k < BITS_PER_STAGE; k++) begin
        if (g * BITS_PER_STAGE + k < WIDTH) begin
          trial = {rem_next, num_next[WIDTH-1]};
          num_next = {num_next[WIDTH-2:0], 1'b0};
          if (trial >= {1'b0, den[g]}) begin
            trial = trial - {1'b0, den[g]};
            num_next[0] = 1'b1;
          end
          rem_next = trial[WIDTH-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num[g+1]  <= num_next;
        rem[g+1]  <= rem_next;
        den[g+1]  <= den[g];
        side[g+1] <= side[g];
      end
    end
  end

  assign quotient  = num[STAGES];
  assign remainder = rem[STAGES];
  assign side_out  = side[STAGES];

endmodule

@@ rtl/sia_quick.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_quick
// combinational operations: logic, shifts, compares, add, sub, unary
// ----------------------------------------------------------------------------
module sia_quick #(
  parameter int unsigned WIDTH = 32
) (
  input  logic [sia_pkg::OP_WIDTH-1:0] operation,
  input  logic [WIDTH-1:0]             a,
  input  logic [WIDTH-1:0]             b,
  input  logic [$clog2(WIDTH)-1:0]     shamt,
  output logic [WIDTH-1:0]             value,
  output logic                         supported
);

  logic lt_ab;
  logic lt_ba;

  assign lt_ab = $signed(a) < $signed(b);
  assign lt_ba = $signed(b) < $signed(a);

  always_comb begin
    value = '0;
    supported = 1'b1;
    unique case (operation)
      sia_pkg::OP_ADD:  value = a + b;
      sia_pkg::OP_SUB:  value = a - b;
      sia_pkg::OP_AND:  value = a & b;
      sia_pkg::OP_OR:   value = a | b;
      sia_pkg::OP_XOR:  value = a ^ b;
      sia_pkg::OP_SRA:  value = WIDTH'($signed(a) >>> shamt);
      sia_pkg::OP_SLL:  value = a << shamt;
      sia_pkg::OP_SRL:  value = a >> shamt;
      sia_pkg::OP_EQ:   value = WIDTH'(a == b);
      sia_pkg::OP_NE:   value = WIDTH'(a != b);
      sia_pkg::OP_LE:   value = WIDTH'(!lt_ba);
      sia_pkg::OP_GE:   value = WIDTH'(!lt_ab);
      sia_pkg::OP_LT:   value = WIDTH'(lt_ab);
      sia_pkg::OP_GT:   value = WIDTH'(lt_ba);
      sia_pkg::OP_LAND: value = WIDTH'((a != '0) && (b != '0));
      sia_pkg::OP_LOR:  value = WIDTH'((a != '0) || (b != '0));
      sia_pkg::OP_POS:  value = b;
      sia_pkg::OP_NEG:  value = '0 - b;
      sia_pkg::OP_NOT:  value = ~b;
      sia_pkg::OP_MUL, sia_pkg::OP_DIV, sia_pkg::OP_MOD: value = '0;
      default: supported = 1'b0;
    endcase
  end

endmodule

@@ rtl/script_integer_alu_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_integer_alu_unit
// pipelined integer alu for script operators, unless stalled one beat per cycle
// ----------------------------------------------------------------------------
// Takes one beat every cycle while the output is not stalled and returns
// one result beat per input beat, in order. Operands are captured, then quick
// ops and partial products are registered, then the divider stages run, four
// quotient bits per stage; every operation runs the same depth. Multiply is
// registered between a half-width partial product stage and the final sum. A
// stall at the output freezes the whole pipeline, so nothing is lost or repeated.
module script_integer_alu_unit #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sia_pkg::in_beat_t   in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output sia_pkg::out_beat_t  out_beat
);

  localparam int unsigned W      = DATA_WIDTH;
  localparam int unsigned VW     = sia_pkg::VALUE_WIDTH;
  localparam int unsigned OPW    = sia_pkg::OP_WIDTH;
  localparam int unsigned BPS    = 4;
  localparam int unsigned DSTG   = (W + BPS - 1) / BPS;
  localparam int unsigned HW     = (W + 1) / 2;
  localparam int unsigned SW     = $clog2(W);
  localparam bit          W_POW2 = (W & (W - 1)) == 0;
  localparam int unsigned FOLD_W = 21;
  // side data: op, neg_q, neg_r, special (zero divisor), product, quick, supported
  localparam int unsigned SIDE_W = OPW + 3 + W + W + 1;

  // 256**k modulo the width
  function automatic int unsigned chunk_weight(int unsigned k);
    int unsigned r;
    r = 1 % W;
    for (int unsigned i = 0; i < 8 * k; i++) r = (2 * r) % W;
    return r;
  endfunction

  localparam int unsigned WEIGHT [8] = '{
    chunk_weight(0), chunk_weight(1), chunk_weight(2), chunk_weight(3),
    chunk_weight(4), chunk_weight(5), chunk_weight(6), chunk_weight(7)
  };

  // shift amount is v modulo the width: byte fold, then compare and subtract
  function automatic logic [SW-1:0] shift_amount(logic [W-1:0] v);
    logic [63:0]       wide;
    logic [FOLD_W-1:0] acc;
    wide = 64'(v);
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      acc = acc + FOLD_W'(wide[8*k +: 8]) * FOLD_W'(WEIGHT[k]);
    end
    for (int j = 14; j >= 0; j--) begin
      if (acc >= FOLD_W'(W << j)) acc = acc - FOLD_W'(W << j);
    end
    return W_POW2 ? v[SW-1:0] : SW'(acc);
  endfunction

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: operand capture
  logic           s1_valid;
  logic [OPW-1:0] s1_op;
  logic [W-1:0]   s1_a;
  logic [W-1:0]   s1_b;
  logic [SW-1:0]  s1_shamt;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op    <= in_beat.operation;
      s1_a     <= W'(in_beat.left_operand);
      s1_b     <= W'(in_beat.right_operand);
      s1_shamt <= shift_amount(W'(in_beat.right_operand));
    end
  end

  // stage 2: quick ops, partial products, divider operand prep
  logic [W-1:0] q_value;
  logic         q_sup;

  sia_quick #(.WIDTH(W)) u_quick (
    .operation (s1_op),
    .a         (s1_a),
    .b         (s1_b),
    .shamt     (s1_shamt),
    .value     (q_value),
    .supported (q_sup)
  );

  logic [W-1:0] mag_a;
  logic [W-1:0] mag_b;
  assign mag_a = s1_a[W-1] ? ('0 - s1_a) : s1_a;
  assign mag_b = s1_b[W-1] ? ('0 - s1_b) : s1_b;

  logic           s2_valid;
  logic [OPW-1:0] s2_op;
  logic [W-1:0]   s2_quick;
  logic           s2_sup;
  logic [W-1:0]   s2_mag_a;
  logic [W-1:0]   s2_mag_b;
  logic           s2_neg_q;
  logic           s2_neg_r;
  logic           s2_zero;
  logic [W-1:0]   s2_pp_ll;
  logic [W-1:0]   s2_pp_lh;
  logic [W-1:0]   s2_pp_hl;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_op    <= s1_op;
      s2_quick <= q_value;
      s2_sup   <= q_sup;
      s2_mag_a <= mag_a;
      s2_mag_b <= mag_b;
      s2_neg_q <= s1_a[W-1] ^ s1_b[W-1];
      s2_neg_r <= s1_a[W-1];
      s2_zero  <= (s1_b == '0);
      s2_pp_ll <= W'(64'(s1_a[HW-1:0]) * 64'(s1_b[HW-1:0]));
      s2_pp_lh <= W'(64'(s1_a[HW-1:0]) * 64'(s1_b[W-1:HW]));
      s2_pp_hl <= W'(64'(s1_a[W-1:HW]) * 64'(s1_b[HW-1:0]));
    end
  end

  // stage 3: product sum; enter divider
  logic [W-1:0] product;
  assign product = s2_pp_ll + W'({s2_pp_lh + s2_pp_hl, {HW{1'b0}}});

  logic [SIDE_W-1:0] side_in;
  logic [SIDE_W-1:0] side_out;
  assign side_in = {s2_op, s2_neg_q, s2_neg_r, s2_zero, product, s2_quick, s2_sup};

  logic [W-1:0] quo;
  logic [W-1:0] rem;

  sia_divider #(.WIDTH(W), .BITS_PER_STAGE(BPS), .SIDE_WIDTH(SIDE_W)) u_div (
    .clk       (clk),
    .en        (en),
    .dividend  (s2_mag_a),
    .divisor   (s2_mag_b),
    .side_in   (side_in),
    .quotient  (quo),
    .remainder (rem),
    .side_out  (side_out)
  );

  logic [DSTG-1:0] dv_valid;
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid <= '0;
    end else if (en) begin
      dv_valid <= {dv_valid[DSTG-2:0], s2_valid};
    end
  end

  // final stage: select and sign fix
  logic [OPW-1:0] f_op;
  logic           f_neg_q;
  logic           f_neg_r;
  logic           f_zero;
  logic [W-1:0]   f_prod;
  logic [W-1:0]   f_quick;
  logic           f_sup;
  assign {f_op, f_neg_q, f_neg_r, f_zero, f_prod, f_quick, f_sup} = side_out;

  logic [W-1:0] sel;
  always_comb begin
    unique case (f_op)
      sia_pkg::OP_MUL: sel = f_prod;
      sia_pkg::OP_DIV: sel = f_zero ? '0 : (f_neg_q ? ('0 - quo) : quo);
      sia_pkg::OP_MOD: sel = f_zero ? '0 : (f_neg_r ? ('0 - rem) : rem);
      default:         sel = f_quick;
    endcase
  end

  logic [VW-1:0] sel_out;
  assign sel_out = VW'(sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid[DSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_beat.result_value <= f_sup ? sel_out : '0;
      out_beat.result_valid <= f_sup;
    end
  end

endmodule
